/* sv/sha384_pkg.sv */
// sha384_pkg: payload types, round constants and a sha-512 rotate helper function
// shared by the controller, datapath and top level of the sha-384 engine
package sha384_pkg;

	typedef struct packed {
		logic [63:0] data_word;
		logic [3:0]  byte_count;
		logic        last_word;
	} in_word_t;

	typedef struct packed {
		logic [63:0] digest_word;
		logic [2:0]  digest_index;
		logic        last_of_run;
	} out_word_t;

	localparam int NumRounds = 80;
	localparam int NumDigest = 6;

	// datapath commands issued by the controller
	typedef struct packed {
		logic load_word;   // absorb bytes of the input word
		logic pad_byte;    // append one pad byte (0x80 first, then zeros)
		logic pad_first;   // pad byte is 0x80
		logic push_zero;   // push a zero schedule word
		logic push_len;    // push the bit length
		logic comp_start;  // copy hash into working vars
		logic comp_round;  // run one round
		logic comp_end;    // fold working vars into hash
		logic msg_done;    // reload initial values and clear counters
	} dp_cmd_t;

	typedef struct packed {
		logic       block_full;   // sixteen schedule words are in
		logic       byte_aligned; // partial word empty
		logic [3:0] word_pos;
	} dp_stat_t;

	localparam logic [63:0] InitHash [8] = '{
		64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17,
		64'h152fecd8f70e5939, 64'h67332667ffc00b31, 64'h8eb44a8768581511,
		64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
	};

	localparam logic [63:0] RoundK [80] = '{
		64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
		64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
		64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
		64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
		64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
		64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
		64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
		64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
		64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
		64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
		64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
		64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
		64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
		64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
		64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
		64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
		64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
		64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
		64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
		64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
	};

	function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
		return (x >> n) | (x << (64 - n));
	endfunction

endpackage

/* sv/sha384_dp.sv */
// sha384_dp: byte packer, schedule window, round logic and hash registers
// depends on sha384_pkg; driven by sha384_ctrl through dp_cmd_t
module sha384_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sha384_pkg::in_word_t  in_word,
	input  sha384_pkg::dp_cmd_t   cmd,
	input  logic [6:0]            round_idx,
	input  logic [2:0]            out_idx,
	output sha384_pkg::dp_stat_t  stat,
	output logic [63:0]           digest_word
);
	import sha384_pkg::*;

	logic [63:0] hash_q [8];
	logic [63:0] var_q [8];
	logic [63:0] win_q [16];
	logic [3:0]  wpos_q;
	logic [60:0] bytes_q;
	logic [63:0] part_q;
	logic [2:0]  pfill_q;   // bytes held in part_q
	logic        full_q;

	// byte packing of the incoming word into the partial word
	logic [3:0]   cnt;
	logic [127:0] merged;
	logic [4:0]   total;
	logic [63:0]  new_word;
	logic         word_done;
	logic [2:0]   rem;
	logic [63:0]  rem_part;
	logic [7:0]   pad_val;

	always_comb begin
		cnt = (in_word.byte_count > 4'd8) ? 4'd8 : in_word.byte_count;
		pad_val = cmd.pad_first ? 8'h80 : 8'h00;
		if (cmd.pad_byte) begin
			merged = {64'd0, part_q} << 8;
			merged[7:0] = pad_val;
			total = {2'b0, pfill_q} + 5'd1;
		end else begin
			// keep only cnt leading bytes of data, shift them in below part_q
			merged = ({64'd0, part_q} << {cnt, 3'b0})
				| ({64'd0, in_word.data_word} >> {4'd8 - cnt, 3'b0});
			total = {2'b0, pfill_q} + {1'b0, cnt};
		end
		word_done = total >= 5'd8;
		rem = total[2:0];
		new_word = merged[{rem, 3'b0} +: 64];
		rem_part = merged[63:0] & ~(64'hffff_ffff_ffff_ffff << {rem, 3'b0});
		if (rem == 3'd0) rem_part = 64'd0;
	end

	// round logic
	logic [3:0]  ti;
	logic [63:0] x15, x2, sg0, sg1, wnew, w, t1, t2;
	always_comb begin
		ti = round_idx[3:0];
		x15 = win_q[ti + 4'd1];
		x2 = win_q[ti + 4'd14];
		sg0 = rotr(x15, 1) ^ rotr(x15, 8) ^ (x15 >> 7);
		sg1 = rotr(x2, 19) ^ rotr(x2, 61) ^ (x2 >> 6);
		wnew = win_q[ti] + sg0 + win_q[ti + 4'd9] + sg1;
		w = (round_idx >= 7'd16) ? wnew : win_q[ti];
		t1 = var_q[7] + (rotr(var_q[4], 14) ^ rotr(var_q[4], 18) ^ rotr(var_q[4], 41))
			+ ((var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]))
			+ RoundK[round_idx] + w;
		t2 = (rotr(var_q[0], 28) ^ rotr(var_q[0], 34) ^ rotr(var_q[0], 39))
			+ ((var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]));
	end

	logic        push;
	logic [63:0] push_val;
	always_comb begin
		push = 1'b0;
		push_val = new_word;
		if (cmd.push_zero) begin
			push = 1'b1;
			push_val = 64'd0;
		end else if (cmd.push_len) begin
			push = 1'b1;
			push_val = {bytes_q, 3'b0};
		end else if ((cmd.load_word || cmd.pad_byte) && word_done) begin
			push = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) win_q[wpos_q] <= push_val;
		else if (cmd.comp_round) win_q[ti] <= w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= InitHash[i];
				var_q[i] <= '0;
			end
			wpos_q <= '0;
			bytes_q <= '0;
			part_q <= '0;
			pfill_q <= '0;
			full_q <= 1'b0;
		end else begin
			if (cmd.load_word || cmd.pad_byte) begin
				part_q <= word_done ? rem_part : merged[63:0];
				pfill_q <= rem;
			end
			if (cmd.load_word) bytes_q <= bytes_q + {57'd0, cnt};
			if (push) begin
				wpos_q <= wpos_q + 4'd1;
				full_q <= (wpos_q == 4'd15);
			end
			if (cmd.comp_start) begin
				full_q <= 1'b0;
				for (int i = 0; i < 8; i++) var_q[i] <= hash_q[i];
			end
			if (cmd.comp_round) begin
				var_q[7] <= var_q[6];
				var_q[6] <= var_q[5];
				var_q[5] <= var_q[4];
				var_q[4] <= var_q[3] + t1;
				var_q[3] <= var_q[2];
				var_q[2] <= var_q[1];
				var_q[1] <= var_q[0];
				var_q[0] <= t1 + t2;
			end
			if (cmd.comp_end)
				for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + var_q[i];
			if (cmd.msg_done) begin
				for (int i = 0; i < 8; i++) hash_q[i] <= InitHash[i];
				wpos_q <= '0;
				bytes_q <= '0;
				part_q <= '0;
				pfill_q <= '0;
			end
		end
	end

	assign stat.block_full = full_q;
	assign stat.byte_aligned = (pfill_q == 3'd0);
	assign stat.word_pos = wpos_q;
	assign digest_word = hash_q[out_idx];

endmodule

/* sv/sha384_ctrl.sv */
// sha384_ctrl: sequencer for absorb, padding, compression and digest output
// depends on sha384_pkg; commands sha384_dp
module sha384_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_last,
	input  logic                 out_stall,
	input  sha384_pkg::dp_stat_t stat,
	output sha384_pkg::dp_cmd_t  cmd,
	output logic                 in_stall,
	output logic                 out_valid,
	output logic [6:0]           round_idx,
	output logic [2:0]           out_idx
);
	import sha384_pkg::*;

	typedef enum logic [2:0] {
		IDLE, PAD_FIRST, PAD_ZERO, PAD_LEN, START, ROUND, FINISH, EMIT
	} state_t;

	state_t     state_q;
	state_t     ret_q;   // where to go once the compression is done
	logic [6:0] round_q;
	logic [2:0] oidx_q;
	logic       accept;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != IDLE) || stat.block_full;
	assign out_valid = (state_q == EMIT);
	assign round_idx = round_q;
	assign out_idx = oidx_q;

	always_comb begin
		cmd = '0;
		cmd.load_word = accept;
		case (state_q)
			PAD_FIRST: begin
				// a full block is compressed before the 0x80 byte goes in
				if (!stat.block_full) begin
					cmd.pad_byte = 1'b1;
					cmd.pad_first = 1'b1;
				end
			end
			PAD_ZERO: begin
				if (!stat.block_full && !(stat.byte_aligned && stat.word_pos == 4'd14))
					cmd.pad_byte = 1'b1;
			end
			PAD_LEN: begin
				if (stat.word_pos == 4'd14) cmd.push_zero = 1'b1;
				else cmd.push_len = 1'b1;
			end
			START: cmd.comp_start = 1'b1;
			ROUND: cmd.comp_round = 1'b1;
			FINISH: cmd.comp_end = 1'b1;
			EMIT: cmd.msg_done = !out_stall && (oidx_q == 3'(NumDigest - 1));
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			ret_q <= IDLE;
			round_q <= '0;
			oidx_q <= '0;
		end else begin
			case (state_q)
				IDLE: begin
					if (stat.block_full) begin
						state_q <= START;
						ret_q <= IDLE;
					end else if (accept && in_last) begin
						state_q <= PAD_FIRST;
					end
				end
				PAD_FIRST: begin
					if (stat.block_full) begin
						state_q <= START;
						ret_q <= PAD_FIRST;
					end else begin
						// a block may fill on the 0x80 byte
						state_q <= PAD_ZERO;
					end
				end
				PAD_ZERO: begin
					if (stat.block_full) begin
						state_q <= START;
						ret_q <= PAD_ZERO;
					end else if (stat.byte_aligned && stat.word_pos == 4'd14) begin
						state_q <= PAD_LEN;
					end
				end
				PAD_LEN: begin
					if (stat.word_pos == 4'd15) state_q <= START;
					ret_q <= EMIT;
				end
				START: begin
					round_q <= '0;
					state_q <= ROUND;
				end
				ROUND: begin
					if (round_q == 7'(NumRounds - 1)) state_q <= FINISH;
					else round_q <= round_q + 7'd1;
				end
				FINISH: begin
					round_q <= '0;
					oidx_q <= '0;
					state_q <= ret_q;
				end
				EMIT: begin
					if (!out_stall) begin
						if (oidx_q == 3'(NumDigest - 1)) begin
							state_q <= IDLE;
							ret_q <= IDLE;
							oidx_q <= '0;
						end else begin
							oidx_q <= oidx_q + 3'd1;
						end
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

/* sv/sha384_hash_engine_top.sv */
// sha384_hash_engine_top: streaming sha-384 engine with hardware padding
// depends on sha384_pkg, sha384_ctrl and sha384_dp
//
// input channel: in_valid/in_stall with in_data (in_word_t), one 64-bit
// message word per transfer with a byte count and last-word flag.
// output channel: out_valid/out_stall with out_data (out_word_t), six
// digest words after each message, index 0 first, last_of_run on index 5.
// a word that does not complete a block or end the message leaves in_stall
// low. each full 128-byte block is compressed (one round per cycle on the
// shared round unit, plus load and fold), during which in_stall is high.
// the last word adds the padding bytes, one per cycle unless a full block
// is compressed first, and one or two compressions before the digest.
// the digest is held in the hash registers and shown one word per cycle;
// out_stall holds the current word. reset loads the initial hash values
// and clears all counters; the block is ready right after reset.
module sha384_hash_engine_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  sha384_pkg::in_word_t in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output sha384_pkg::out_word_t out_data
);
	import sha384_pkg::*;

	dp_cmd_t     cmd;
	dp_stat_t    stat;
	logic [6:0]  round_idx;
	logic [2:0]  out_idx;
	logic [63:0] digest_word;

	sha384_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_last(in_data.last_word), .out_stall,
		.stat, .cmd, .in_stall, .out_valid, .round_idx, .out_idx
	);

	sha384_dp u_dp (
		.clk, .arst_n, .in_word(in_data), .cmd, .round_idx, .out_idx,
		.stat, .digest_word
	);

	assign out_data.digest_word = digest_word;
	assign out_data.digest_index = out_idx;
	assign out_data.last_of_run = (out_idx == 3'(NumDigest - 1));

endmodule

/* sv/sha384_checker.sv */
// sha384_port_checker: port-level assertions for sha384_hash_engine_top
// depends on sha384_pkg; attached by bind below
module sha384_port_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input sha384_pkg::in_word_t  in_data,
	input logic                  out_valid,
	input logic                  out_stall,
	input sha384_pkg::out_word_t out_data
);
	import sha384_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled digest word changed");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.digest_index <= 3'd5)
		else $error("digest index out of range");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.last_of_run == (out_data.digest_index == 3'd5))
		else $error("last_of_run mismatch");

	a_no_input_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken during digest output");

	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && out_data.digest_index != 3'd5 |=>
		out_valid && out_data.digest_index == $past(out_data.digest_index) + 3'd1)
		else $error("digest index did not advance");

endmodule

bind sha384_hash_engine_top sha384_port_checker u_checker (.*);

/* sim/sha384_checker.sv */
`timescale 1ns / 1ps
// sha384_checker: watches both channels of the sha-384 engine, predicts the
// digest words and compares them; depends on sha384_pkg
module sha384_checker (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  sha384_pkg::in_word_t  in_data,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  sha384_pkg::out_word_t out_data,
	output int                    fail_count,
	output int                    pending
);
	import sha384_pkg::*;

	logic [63:0] hv [8];
	logic [63:0] sched [16];
	logic [3:0]  wpos;
	logic [60:0] nbytes;
	logic [63:0] pack;
	out_word_t   digest_q [$];

	function automatic logic [63:0] rr(input logic [63:0] x, input int n);
		return (x >> n) | (x << (64 - n));
	endfunction

	task automatic compress();
		logic [63:0] v [8];
		logic [63:0] s0, s1, t1, t2, x15, x2;
		for (int i = 0; i < 8; i++) v[i] = hv[i];
		for (int t = 0; t < NumRounds; t++) begin
			if (t >= 16) begin
				x15 = sched[(t - 15) & 15];
				x2 = sched[(t - 2) & 15];
				s0 = rr(x15, 1) ^ rr(x15, 8) ^ (x15 >> 7);
				s1 = rr(x2, 19) ^ rr(x2, 61) ^ (x2 >> 6);
				sched[t & 15] = sched[t & 15] + s0 + sched[(t - 7) & 15] + s1;
			end
			t1 = v[7] + (rr(v[4], 14) ^ rr(v[4], 18) ^ rr(v[4], 41))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[t] + sched[t & 15];
			t2 = (rr(v[0], 28) ^ rr(v[0], 34) ^ rr(v[0], 39))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			for (int i = 7; i > 0; i--) v[i] = v[i - 1];
			v[4] = v[4] + t1;
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) hv[i] += v[i];
	endtask

	task automatic push_sched(input logic [63:0] w);
		sched[wpos] = w;
		wpos = wpos + 4'd1;
		if (wpos == 4'd0) compress();
	endtask

	task automatic add_byte(input logic [7:0] b, input logic [2:0] pos);
		pack = {pack[55:0], b};
		if (pos == 3'd7) begin
			push_sched(pack);
			pack = '0;
		end
	endtask

	task automatic absorb_word(input in_word_t w);
		int cnt;
		logic [2:0] pos;
		out_word_t r;
		cnt = (w.byte_count > 4'd8) ? 8 : int'(w.byte_count);
		for (int k = 0; k < cnt; k++) begin
			add_byte(w.data_word[63 - 8 * k -: 8], nbytes[2:0]);
			nbytes = nbytes + 61'd1;
		end
		if (w.last_word) begin
			pos = nbytes[2:0];
			add_byte(8'h80, pos);
			pos = pos + 3'd1;
			while (!(pos == 3'd0 && wpos == 4'd14)) begin
				add_byte(8'h00, pos);
				pos = pos + 3'd1;
			end
			push_sched('0);
			push_sched({nbytes, 3'b000});
			for (int k = 0; k < NumDigest; k++) begin
				r.digest_word = hv[k];
				r.digest_index = 3'(k);
				r.last_of_run = (k == NumDigest - 1);
				digest_q.push_back(r);
			end
			for (int i = 0; i < 8; i++) hv[i] = InitHash[i];
			wpos = '0;
			nbytes = '0;
			pack = '0;
		end
	endtask

	initial begin
		fail_count = 0;
		for (int i = 0; i < 8; i++) hv[i] = InitHash[i];
		wpos = '0;
		nbytes = '0;
		pack = '0;
	end

	assign pending = digest_q.size();

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) absorb_word(in_data);
			if (out_valid && !out_stall) begin
				if (digest_q.size() == 0) begin
					$display("%0t: unexpected digest word %h", $time, out_data);
					fail_count++;
				end else begin
					if (out_data !== digest_q[0]) begin
						$display("%0t: expected %h/%0d/%0d actual %h/%0d/%0d", $time,
							digest_q[0].digest_word, digest_q[0].digest_index,
							digest_q[0].last_of_run, out_data.digest_word,
							out_data.digest_index, out_data.last_of_run);
						fail_count++;
					end
					void'(digest_q.pop_front());
				end
			end
		end
	end
endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// tb: stimulus and verdict for the sha-384 engine
// depends on sha384_pkg, sha384_hash_engine_top and sha384_checker
module tb;
	import sha384_pkg::*;

	logic      clk = 0;
	logic      arst_n = 0;
	logic      in_valid = 0;
	logic      in_stall;
	in_word_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 0;
	out_word_t out_data;
	int        fail_count;
	int        pending;
	bit        long_hold = 0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	sha384_hash_engine_top u_top (.*);

	sha384_checker u_chk (.*);

	// valid stays high straight into the next word when there is no gap
	task automatic send_word(input logic [63:0] d, input logic [3:0] c, input logic l);
		int gap;
		gap = $urandom_range(0, 10);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		in_data <= '{data_word: d, byte_count: c, last_word: l};
		do @(posedge clk); while (in_stall);
	endtask

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	task automatic wait_drained();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// receiver: random stall per word, one long hold-off on request
	initial begin
		int w;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_stall <= 1;
				repeat (600) @(posedge clk);
				out_stall <= 0;
				long_hold = 0;
				@(posedge clk);
			end
			w = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
			if (w != 0) begin
				out_stall <= 1;
				repeat (w) @(posedge clk);
				out_stall <= 0;
			end
			@(posedge clk);
		end
	end

	initial begin
		int nwords;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// empty message, then extremes of data and counts
		send_word(rnd64(), 4'd0, 1);
		send_word('1, 4'd8, 1);
		send_word('0, 4'd8, 1);
		send_word(64'h6162630000000000, 4'd3, 1);
		for (int c = 0; c <= 15; c++) send_word(rnd64(), 4'(c), (c % 4) == 3);
		// 15 full words then last: padding spills into a second block
		for (int i = 0; i < 15; i++) send_word(rnd64(), 4'd8, 0);
		send_word(rnd64(), 4'd8, 1);
		send_word(rnd64(), 4'd0, 1);
		wait_drained();
		// long receiver hold while the sender keeps going
		long_hold = 1;
		for (int m = 0; m < 4; m++) begin
			for (int i = 0; i < 3; i++) send_word(rnd64(), 4'd8, 0);
			send_word(rnd64(), 4'($urandom_range(0, 8)), 1);
		end
		wait_drained();
		for (int m = 0; m < 40; m++) begin
			nwords = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 5);
			for (int i = 0; i < nwords; i++)
				send_word(rnd64(), ($urandom_range(0, 5) == 0) ?
					4'($urandom_range(0, 15)) : 4'd8, 0);
			send_word(rnd64(), 4'($urandom_range(0, 15)), 1);
			if ($urandom_range(0, 4) == 0) wait_drained();
		end
		wait_drained();
		repeat (200) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#5ms;
		$display("FAIL");
		$finish;
	end
endmodule
